// File: hdl/bc7_block_decoder_assert.svh
// Assertion macros for the BC7 block decoder.
// Used by modules that check their own sequencing; needs clk and rst_n in scope.
`ifndef BC7_BLOCK_DECODER_ASSERT_SVH
`define BC7_BLOCK_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define BC7_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    prop) else $error(msg);
`define BC7_ASSERT_NEVER(lbl, cond, msg) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BC7_ASSERT(lbl, prop, msg)
`define BC7_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: hdl/bc7_pkg.sv
// Shared types, format tables and helper functions for the BC7 block decoder.
// No dependencies.
`default_nettype none
package bc7_pkg;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
    } blk_t;

    typedef struct packed {
        logic [3:0] pixel_pos;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
        logic       error;
    } pix_t;

    typedef enum logic [2:0] {
        MODE0, MODE1, MODE2, MODE3, MODE4, MODE5, MODE6, MODE7
    } mode_t;

    // rotation codes
    localparam logic [1:0] ROT_NONE  = 2'd0;
    localparam logic [1:0] ROT_RED   = 2'd1;
    localparam logic [1:0] ROT_GREEN = 2'd2;
    localparam logic [1:0] ROT_BLUE  = 2'd3;

    // one decoded block, as queued between parser and pixel engine
    typedef struct packed {
        logic                      err;
        mode_t                     mode;
        logic [5:0]                part;
        logic [1:0]                rot;
        logic                      isb;
        logic [5:0][3:0][7:0]      ep;
        logic [63:0]               ix1;
        logic [46:0]               ix2;
    } desc_t;

    localparam logic [15:0] PART2 [64] = '{
        16'hCCCC,16'h8888,16'hEEEE,16'hECC8,16'hC880,16'hFEEC,16'hFEC8,16'hEC80,
        16'hC800,16'hFFEC,16'hFE80,16'hE800,16'hFFE8,16'hFF00,16'hFFF0,16'hF000,
        16'hF710,16'h008E,16'h7100,16'h08CE,16'h008C,16'h7310,16'h3100,16'h8CCE,
        16'h088C,16'h3110,16'h6666,16'h366C,16'h17E8,16'h0FF0,16'h718E,16'h399C,
        16'hAAAA,16'hF0F0,16'h5A5A,16'h33CC,16'h3C3C,16'h55AA,16'h9696,16'hA55A,
        16'h73CE,16'h13C8,16'h324C,16'h3BDC,16'h6996,16'hC33C,16'h9966,16'h0660,
        16'h0272,16'h04E4,16'h4E40,16'h2720,16'hC936,16'h936C,16'h39C6,16'h639C,
        16'h9336,16'h9CC6,16'h817E,16'hE718,16'hCCF0,16'h0FCC,16'h7744,16'hEE22
    };

    localparam logic [1:0] PART3 [64][16] = '{
        '{0,0,1,1,0,0,1,1,0,2,2,1,2,2,2,2},'{0,0,0,1,0,0,1,1,2,2,1,1,2,2,2,1},
        '{0,0,0,0,2,0,0,1,2,2,1,1,2,2,1,1},'{0,2,2,2,0,0,2,2,0,0,1,1,0,1,1,1},
        '{0,0,0,0,0,0,0,0,1,1,2,2,1,1,2,2},'{0,0,1,1,0,0,1,1,0,0,2,2,0,0,2,2},
        '{0,0,2,2,0,0,2,2,1,1,1,1,1,1,1,1},'{0,0,1,1,0,0,1,1,2,2,1,1,2,2,1,1},
        '{0,0,0,0,0,0,0,0,1,1,1,1,2,2,2,2},'{0,0,0,0,1,1,1,1,1,1,1,1,2,2,2,2},
        '{0,0,0,0,1,1,1,1,2,2,2,2,2,2,2,2},'{0,0,1,2,0,0,1,2,0,0,1,2,0,0,1,2},
        '{0,1,1,2,0,1,1,2,0,1,1,2,0,1,1,2},'{0,1,2,2,0,1,2,2,0,1,2,2,0,1,2,2},
        '{0,0,1,1,0,1,1,2,1,1,2,2,1,2,2,2},'{0,0,1,1,2,0,0,1,2,2,0,0,2,2,2,0},
        '{0,0,0,1,0,0,1,1,0,1,1,2,1,1,2,2},'{0,1,1,1,0,0,1,1,2,0,0,1,2,2,0,0},
        '{0,0,0,0,1,1,2,2,1,1,2,2,1,1,2,2},'{0,0,2,2,0,0,2,2,0,0,2,2,1,1,1,1},
        '{0,1,1,1,0,1,1,1,0,2,2,2,0,2,2,2},'{0,0,0,1,0,0,0,1,2,2,2,1,2,2,2,1},
        '{0,0,0,0,0,0,1,1,0,1,2,2,0,1,2,2},'{0,0,0,0,1,1,0,0,2,2,1,0,2,2,1,0},
        '{0,1,2,2,0,1,2,2,0,0,1,1,0,0,0,0},'{0,0,1,2,0,0,1,2,1,1,2,2,2,2,2,2},
        '{0,1,1,0,1,2,2,1,1,2,2,1,0,1,1,0},'{0,0,0,0,0,1,1,0,1,2,2,1,1,2,2,1},
        '{0,0,2,2,1,1,0,2,1,1,0,2,0,0,2,2},'{0,1,1,0,0,1,1,0,2,0,0,2,2,2,2,2},
        '{0,0,1,1,0,1,2,2,0,1,2,2,0,0,1,1},'{0,0,0,0,2,0,0,0,2,2,1,1,2,2,2,1},
        '{0,0,0,0,0,0,0,2,1,1,2,2,1,2,2,2},'{0,2,2,2,0,0,2,2,0,0,1,2,0,0,1,1},
        '{0,0,1,1,0,0,1,2,0,0,2,2,0,2,2,2},'{0,1,2,0,0,1,2,0,0,1,2,0,0,1,2,0},
        '{0,0,0,0,1,1,1,1,2,2,2,2,0,0,0,0},'{0,1,2,0,1,2,0,1,2,0,1,2,0,1,2,0},
        '{0,1,2,0,2,0,1,2,1,2,0,1,0,1,2,0},'{0,0,1,1,2,2,0,0,1,1,2,2,0,0,1,1},
        '{0,0,1,1,1,1,2,2,2,2,0,0,0,0,1,1},'{0,1,0,1,0,1,0,1,2,2,2,2,2,2,2,2},
        '{0,0,0,0,0,0,0,0,2,1,2,1,2,1,2,1},'{0,0,2,2,1,1,2,2,0,0,2,2,1,1,2,2},
        '{0,0,2,2,0,0,1,1,0,0,2,2,0,0,1,1},'{0,2,2,0,1,2,2,1,0,2,2,0,1,2,2,1},
        '{0,1,0,1,2,2,2,2,2,2,2,2,0,1,0,1},'{0,0,0,0,2,1,2,1,2,1,2,1,2,1,2,1},
        '{0,1,0,1,0,1,0,1,0,1,0,1,2,2,2,2},'{0,2,2,2,0,1,1,1,0,2,2,2,0,1,1,1},
        '{0,0,0,2,1,1,1,2,0,0,0,2,1,1,1,2},'{0,0,0,0,2,1,1,2,2,1,1,2,2,1,1,2},
        '{0,2,2,2,0,1,1,1,0,1,1,1,0,2,2,2},'{0,0,0,2,1,1,1,2,1,1,1,2,0,0,0,2},
        '{0,1,1,0,0,1,1,0,0,1,1,0,2,2,2,2},'{0,0,0,0,0,0,0,0,2,1,1,2,2,1,1,2},
        '{0,1,1,0,0,1,1,0,2,2,2,2,2,2,2,2},'{0,0,2,2,0,0,1,1,0,0,1,1,0,0,2,2},
        '{0,0,2,2,1,1,2,2,1,1,2,2,0,0,2,2},'{0,0,0,0,0,0,0,0,0,0,0,0,2,1,1,2},
        '{0,0,0,2,0,0,0,1,0,0,0,2,0,0,0,1},'{0,2,2,2,1,2,2,2,0,2,2,2,1,2,2,2},
        '{0,1,0,1,2,2,2,2,2,2,2,2,2,2,2,2},'{0,1,1,1,2,0,1,1,2,2,0,1,2,2,2,0}
    };

    localparam logic [3:0] ANCH2 [64] = '{
        15,15,15,15,15,15,15,15, 15,15,15,15,15,15,15,15,
        15, 2, 8, 2, 2, 8, 8,15,  2, 8, 2, 2, 8, 8, 2, 2,
        15,15, 6, 8, 2, 8,15,15,  2, 8, 2, 2, 2,15,15, 6,
         6, 2, 6, 8,15,15, 2, 2, 15,15,15,15,15, 2, 2,15
    };

    localparam logic [3:0] ANCH3A [64] = '{
         3, 3,15,15, 8, 3,15,15,  8, 8, 6, 6, 6, 5, 3, 3,
         3, 3, 8,15, 3, 3, 6,10,  5, 8, 8, 6, 8, 5,15,15,
         8,15, 3, 5, 6,10, 8,15, 15, 3,15, 5,15,15,15,15,
         3,15, 5, 5, 5, 8, 5,10,  5,10, 8,13,15,12, 3, 3
    };

    localparam logic [3:0] ANCH3B [64] = '{
        15, 8, 8, 3,15,15, 3, 8, 15,15,15,15,15,15,15, 8,
        15, 8,15, 3,15, 8,15, 8,  3,15, 6,10,15,15,10, 8,
        15, 3,15,10,10, 8, 9,10,  6,15, 8,15, 3, 6, 6, 8,
        15, 3,15,15,15,15,15,15, 15,15,15,15, 3,15,15, 8
    };

    localparam logic [6:0] WT2 [4]  = '{0,21,43,64};
    localparam logic [6:0] WT3 [8]  = '{0,9,18,27,37,46,55,64};
    localparam logic [6:0] WT4 [16] = '{0,4,9,13,17,21,26,30,34,38,43,47,51,55,60,64};

    function automatic logic [6:0] weight_of(input logic [2:0] bits, input logic [3:0] idx);
        logic [6:0] w;
        case (bits)
            3'd2:    w = WT2[idx[1:0]];
            3'd3:    w = WT3[idx[2:0]];
            default: w = WT4[idx];
        endcase
        return w;
    endfunction

    // bit replication up to 8 bits; precision is 5..8 in every mode
    function automatic logic [7:0] widen(input logic [7:0] v, input logic [3:0] p);
        logic [7:0] r;
        case (p)
            4'd5:    r = {v[4:0], v[4:2]};
            4'd6:    r = {v[5:0], v[5:4]};
            4'd7:    r = {v[6:0], v[6]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/bc7_block_decoder.sv
// Top level of the BC7 block decoder: parser, block queue and pixel engine.
// Depends on bc7_pkg, bc7_front, bc7_queue and bc7_back.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------
//   blk     | blk_valid / blk_ready  | blk_t: block_low, block_high
//   pix     | pix_valid / pix_ready  | pix_t: pixel_pos, RGBA, last, error
//
// A block is parsed in the cycle it is taken and waits in a two-entry queue.
// The pixel engine gives one pixel a cycle while pix is not stalled, so a block
// gives 16 pixels (an invalid block one); that engine sets the sustained block rate.
// A block passes the queue, block register, weight stage and output register in turn.
// Reset clears all valid state; stalls on pix hold the output and back up the queue.
`default_nettype none
module bc7_block_decoder
    import bc7_pkg::*;
(
    input  var logic  clk,
    input  var logic  rst_n,
    input  var logic  blk_valid,
    output logic      blk_ready,
    input  var blk_t  blk,
    output logic      pix_valid,
    input  var logic  pix_ready,
    output pix_t      pix
);

    desc_t  parsed;
    desc_t  q_data;
    logic   q_valid, q_ready;

    bc7_front u_front (
        .blk  (blk),
        .desc (parsed)
    );

    bc7_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (blk_valid),
        .wr_ready (blk_ready),
        .wr_data  (parsed),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    bc7_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

endmodule
`default_nettype wire

// File: hdl/bc7_front.sv
// Block parser: finds the mode, pulls out partition, rotation, endpoints and index streams.
// Depends on bc7_pkg.
`default_nettype none
module bc7_front
    import bc7_pkg::*;
(
    input  var blk_t  blk,
    output desc_t     desc
);

    logic [127:0]          b;
    logic [5:0][3:0][7:0]  raw;
    logic [3:0]            cp;
    logic [3:0]            ap;
    mode_t                 mode;

    assign b = {blk.block_high, blk.block_low};

    always_comb
    begin
        mode = MODE0;
        for (int k = 7; k >= 0; k--)
        begin
            if (b[k])
                mode = mode_t'(k[2:0]);
        end

        desc      = '0;
        raw       = '0;
        cp        = 4'd8;
        ap        = 4'd0;
        desc.err  = (b[7:0] == 8'd0);
        desc.mode = mode;

        unique case (mode)
            MODE0:
            begin
                desc.part = {2'b0, b[4:1]};
                for (int e = 0; e < 6; e++)
                    for (int c = 0; c < 3; c++)
                        raw[e][c] = {3'b0, b[5 + (c * 6 + e) * 4 +: 4], b[77 + e]};
                cp = 4'd5;
                desc.ix1 = 64'(b[127:83]);
            end
            MODE1:
            begin
                desc.part = b[7:2];
                for (int e = 0; e < 4; e++)
                    for (int c = 0; c < 3; c++)
                        raw[e][c] = {1'b0, b[8 + (c * 4 + e) * 6 +: 6], b[80 + e / 2]};
                cp = 4'd7;
                desc.ix1 = 64'(b[127:82]);
            end
            MODE2:
            begin
                desc.part = b[8:3];
                for (int e = 0; e < 6; e++)
                    for (int c = 0; c < 3; c++)
                        raw[e][c] = {3'b0, b[9 + (c * 6 + e) * 5 +: 5]};
                cp = 4'd5;
                desc.ix1 = 64'(b[127:99]);
            end
            MODE3:
            begin
                desc.part = b[9:4];
                for (int e = 0; e < 4; e++)
                    for (int c = 0; c < 3; c++)
                        raw[e][c] = {b[10 + (c * 4 + e) * 7 +: 7], b[94 + e]};
                cp = 4'd8;
                desc.ix1 = 64'(b[127:98]);
            end
            MODE4:
            begin
                desc.rot = b[6:5];
                desc.isb = b[7];
                for (int e = 0; e < 2; e++)
                begin
                    for (int c = 0; c < 3; c++)
                        raw[e][c] = {3'b0, b[8 + (c * 2 + e) * 5 +: 5]};
                    raw[e][3] = {2'b0, b[38 + e * 6 +: 6]};
                end
                cp = 4'd5;
                ap = 4'd6;
                desc.ix1 = 64'(b[80:50]);
                desc.ix2 = b[127:81];
            end
            MODE5:
            begin
                desc.rot = b[7:6];
                for (int e = 0; e < 2; e++)
                begin
                    for (int c = 0; c < 3; c++)
                        raw[e][c] = {1'b0, b[8 + (c * 2 + e) * 7 +: 7]};
                    raw[e][3] = b[50 + e * 8 +: 8];
                end
                cp = 4'd7;
                ap = 4'd8;
                desc.ix1 = 64'(b[96:66]);
                desc.ix2 = 47'(b[127:97]);
            end
            MODE6:
            begin
                for (int e = 0; e < 2; e++)
                begin
                    for (int c = 0; c < 3; c++)
                        raw[e][c] = {b[7 + (c * 2 + e) * 7 +: 7], b[63 + e]};
                    raw[e][3] = {b[49 + e * 7 +: 7], b[63 + e]};
                end
                cp = 4'd8;
                ap = 4'd8;
                desc.ix1 = 64'(b[127:65]);
            end
            MODE7:
            begin
                desc.part = b[13:8];
                for (int e = 0; e < 4; e++)
                begin
                    for (int c = 0; c < 3; c++)
                        raw[e][c] = {2'b0, b[14 + (c * 4 + e) * 5 +: 5], b[94 + e]};
                    raw[e][3] = {2'b0, b[74 + e * 5 +: 5], b[94 + e]};
                end
                cp = 4'd6;
                ap = 4'd6;
                desc.ix1 = 64'(b[127:98]);
            end
            default:
            begin
                cp = 4'd8;
            end
        endcase

        for (int e = 0; e < 6; e++)
        begin
            for (int c = 0; c < 3; c++)
                desc.ep[e][c] = widen(raw[e][c], cp);
            desc.ep[e][3] = (ap == 4'd0) ? 8'd255 : widen(raw[e][3], ap);
        end

        // invalid block: zero endpoints make every channel zero
        if (desc.err)
            desc = '{err: 1'b1, mode: MODE0, default: '0};
    end

endmodule
`default_nettype wire

// File: hdl/bc7_queue.sv
// Two-entry queue of decoded blocks between parser and pixel engine.
// Depends on bc7_pkg.
`default_nettype none
module bc7_queue
    import bc7_pkg::*;
(
    input  var logic  clk,
    input  var logic  rst_n,
    input  var logic  wr_valid,
    output logic      wr_ready,
    input  var desc_t wr_data,
    output logic      rd_valid,
    input  var logic  rd_ready,
    output desc_t     rd_data
);

    desc_t       mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// File: hdl/bc7_back.sv
// Pixel engine: walks the 16 pixels of a decoded block, picks indices and weights,
// blends and rotates. Depends on bc7_pkg and bc7_block_decoder_assert.svh.
`default_nettype none
`include "bc7_block_decoder_assert.svh"
module bc7_back
    import bc7_pkg::*;
(
    input  var logic  clk,
    input  var logic  rst_n,
    input  var logic  q_valid,
    output logic      q_ready,
    input  var desc_t q_data,
    output logic      pix_valid,
    input  var logic  pix_ready,
    output pix_t      pix
);

    // current block
    logic         cur_valid_reg, cur_valid_next;
    desc_t        cur_reg, cur_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [63:0]  s1_reg, s1_next;
    logic [46:0]  s2_reg, s2_next;

    // weight stage
    logic               p_valid_reg, p_valid_next;
    logic [3:0][7:0]    p_e0_reg, p_e1_reg;
    logic [6:0]         p_wc_reg, p_wa_reg;
    logic [1:0]         p_rot_reg;
    logic [3:0]         p_idx_reg;
    logic               p_last_reg, p_err_reg;

    // output register
    logic  pix_valid_reg, pix_valid_next;
    pix_t  pix_reg, pix_next;

    logic        p_adv, p_free, emit, is_last, load;
    logic [1:0]  ns, sub;
    logic [2:0]  ib, ib2, len1, len2;
    logic        anchor;
    logic [3:0]  idx1, idx2;
    logic [6:0]  wc, wa;
    logic [2:0]  e0_sel;
    logic [7:0]  ch [4];
    logic        retire_ok, last_ok, pix_zero;

    function automatic logic [7:0] blend(input logic [7:0] e0, input logic [7:0] e1,
                                         input logic [6:0] w);
        logic [14:0] s;
        s = 15'(7'd64 - w) * 15'(e0) + 15'(w) * 15'(e1) + 15'd32;
        return s[13:6];
    endfunction

    function automatic logic [3:0] low_bits(input logic [3:0] v, input logic [2:0] n);
        logic [3:0] r;
        case (n)
            3'd0:    r = 4'd0;
            3'd1:    r = {3'b0, v[0]};
            3'd2:    r = {2'b0, v[1:0]};
            3'd3:    r = {1'b0, v[2:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    assign p_adv   = p_valid_reg && (!pix_valid_reg || pix_ready);
    assign p_free  = !p_valid_reg || p_adv;
    assign emit    = cur_valid_reg && p_free;
    assign is_last = cur_reg.err || (cnt_reg == 4'd15);
    assign load    = !cur_valid_reg || (emit && is_last);
    assign q_ready = load;

    // per-pixel index and weight selection
    always_comb
    begin
        unique case (cur_reg.mode)
            MODE0, MODE2:        ns = 2'd3;
            MODE1, MODE3, MODE7: ns = 2'd2;
            default:             ns = 2'd1;
        endcase
        unique case (cur_reg.mode)
            MODE0, MODE1: ib = 3'd3;
            MODE6:        ib = 3'd4;
            default:      ib = 3'd2;
        endcase
        unique case (cur_reg.mode)
            MODE4:   ib2 = 3'd3;
            MODE5:   ib2 = 3'd2;
            default: ib2 = 3'd0;
        endcase

        if (ns == 2'd2)
            sub = {1'b0, PART2[cur_reg.part][cnt_reg]};
        else if (ns == 2'd3)
            sub = PART3[cur_reg.part][cnt_reg];
        else
            sub = 2'd0;

        anchor = (cnt_reg == 4'd0)
              || (ns == 2'd2 && sub == 2'd1 && cnt_reg == ANCH2[cur_reg.part])
              || (ns == 2'd3 && sub == 2'd1 && cnt_reg == ANCH3A[cur_reg.part])
              || (ns == 2'd3 && sub == 2'd2 && cnt_reg == ANCH3B[cur_reg.part]);

        len1 = 3'(ib - {2'b0, anchor});
        len2 = (ib2 == 3'd0) ? 3'd0 : 3'(ib2 - {2'b0, cnt_reg == 4'd0});
        idx1 = low_bits(s1_reg[3:0], len1);
        idx2 = low_bits(s2_reg[3:0], len2);

        if (ib2 == 3'd0)
        begin
            wc = weight_of(ib, idx1);
            wa = wc;
        end
        else if (!cur_reg.isb)
        begin
            wc = weight_of(ib, idx1);
            wa = weight_of(ib2, idx2);
        end
        else
        begin
            wc = weight_of(ib2, idx2);
            wa = weight_of(ib, idx1);
        end

        e0_sel = {sub, 1'b0};

        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        if (load)
        begin
            cur_valid_next = q_valid;
            cur_next       = q_data;
            cnt_next       = 4'd0;
            s1_next        = q_data.ix1;
            s2_next        = q_data.ix2;
        end
        else if (emit)
        begin
            cnt_next = 4'(cnt_reg + 4'd1);
            s1_next  = s1_reg >> len1;
            s2_next  = s2_reg >> len2;
        end
    end

    // blend, rotate, and the output handshake
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            ch[c] = blend(p_e0_reg[c], p_e1_reg[c], p_wc_reg);
        ch[3] = blend(p_e0_reg[3], p_e1_reg[3], p_wa_reg);

        pix_next           = pix_reg;
        pix_next.pixel_pos = p_idx_reg;
        pix_next.last      = p_last_reg;
        pix_next.error     = p_err_reg;
        pix_next.red       = ch[0];
        pix_next.green     = ch[1];
        pix_next.blue      = ch[2];
        pix_next.alpha     = ch[3];
        case (p_rot_reg)
            ROT_RED:
            begin
                pix_next.red   = ch[3];
                pix_next.alpha = ch[0];
            end
            ROT_GREEN:
            begin
                pix_next.green = ch[3];
                pix_next.alpha = ch[1];
            end
            ROT_BLUE:
            begin
                pix_next.blue  = ch[3];
                pix_next.alpha = ch[2];
            end
            default:
            begin
                pix_next.alpha = ch[3];
            end
        endcase

        if (p_adv)
            pix_valid_next = 1'b1;
        else if (pix_ready)
            pix_valid_next = 1'b0;
        else
            pix_valid_next = pix_valid_reg;

        if (emit)
            p_valid_next = 1'b1;
        else if (p_adv)
            p_valid_next = 1'b0;
        else
            p_valid_next = p_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
            p_valid_reg   <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cnt_reg       <= cnt_next;
            p_valid_reg   <= p_valid_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        if (emit)
        begin
            p_e0_reg   <= cur_reg.ep[e0_sel];
            p_e1_reg   <= cur_reg.ep[3'(e0_sel + 3'd1)];
            p_wc_reg   <= wc;
            p_wa_reg   <= wa;
            p_rot_reg  <= cur_reg.rot;
            p_idx_reg  <= cnt_reg;
            p_last_reg <= is_last;
            p_err_reg  <= cur_reg.err;
        end
        if (p_adv)
            pix_reg <= pix_next;
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    assign retire_ok = !(cur_valid_reg && load && !cur_reg.err) || (cnt_reg == 4'd15);
    assign last_ok   = (pix_reg.pixel_pos == 4'd15) || pix_reg.error;
    assign pix_zero  = (pix_reg.red == 8'd0) && (pix_reg.green == 8'd0)
                    && (pix_reg.blue == 8'd0) && (pix_reg.alpha == 8'd0)
                    && (pix_reg.pixel_pos == 4'd0);

    `BC7_ASSERT(a_full_block, retire_ok, "block retired early")
    `BC7_ASSERT(a_last_pos, (pix_valid_reg && pix_reg.last) |-> last_ok, "last on wrong pixel")
    `BC7_ASSERT(a_err_zero, (pix_valid_reg && pix_reg.error) |-> (pix_zero && pix_reg.last), "bad error item")
    `BC7_ASSERT_NEVER(a_err_single, cur_valid_reg && cur_reg.err && cnt_reg != 4'd0, "error block stepped")

endmodule
`default_nettype wire
